/* design/ctl_pkg.sv */
// Shared types and constants for the closed tour length block.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package ctl_pkg;

    // Default parameter values
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    // Fixed payload widths
    localparam int PT_W  = 16;
    localparam int SUM_W = 35;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_LEG_A,
        S_LEG_B,
        S_EMIT
    } t_ctl_state;

    // Square root unit phases
    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_SQUARE,
        SQ_LOAD,
        SQ_ITER
    } t_sq_phase;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_pt;   // capture the accepted point
        logic first_pt;  // open a tour with the captured point
        logic start_a;   // start the leg from previous to current point
        logic start_b;   // start the closing leg from current to first point
        logic add_leg;   // add the finished leg and advance the previous point
        logic emit;      // load the output register and clear the tour
    } t_ctl_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic in_tour;
        logic last_pt;
        logic leg_done;
        logic sq_busy;
        logic out_free;
    } t_ctl_stat;

endpackage

`default_nettype wire

/* design/ctl_intf.sv */
// Valid/ready channel interfaces: tour points in, tour lengths out.
// Depends on ctl_pkg for payload widths.
`default_nettype none

interface ctl_pt_if;
    logic                      valid;
    logic                      ready;
    logic [ctl_pkg::PT_W-1:0]  x;
    logic [ctl_pkg::PT_W-1:0]  y;
    logic                      last;

    modport source (output valid, output x, output y, output last, input ready);
    modport sink   (input valid, input x, input y, input last, output ready);
endinterface

interface ctl_len_if;
    logic                       valid;
    logic                       ready;
    logic [ctl_pkg::SUM_W-1:0]  tour_length;
    logic                       saturated;

    modport source (output valid, output tour_length, output saturated, input ready);
    modport sink   (input valid, input tour_length, input saturated, output ready);
endinterface

`default_nettype wire

/* design/ctl_sqrt.sv */
// Leg length unit: |dx|,|dy|, squares, then a digit-by-digit square root,
// one root bit per cycle. Depends on ctl_pkg for the phase type.
`default_nettype none

module ctl_sqrt #(
    parameter int CW        = ctl_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS = ctl_pkg::FRAC_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [CW-1:0] i_ax,
    input  wire logic [CW-1:0] i_ay,
    input  wire logic [CW-1:0] i_bx,
    input  wire logic [CW-1:0] i_by,
    output logic               o_busy,
    output logic               o_done,
    output logic [CW+FRAC_BITS:0] o_root
);

    localparam int RB   = CW + 1 + FRAC_BITS;   // root bits
    localparam int RMW  = RB + 2;               // remainder bits
    localparam int RADW = 2 * RB;               // radicand bits
    localparam int SW   = 2 * CW + 1;           // sum of squares bits
    localparam int CNTW = $clog2(RB);

    ctl_pkg::t_sq_phase r_phase, n_phase;
    logic              r_done;
    logic [CNTW-1:0]   r_cnt;
    logic [CW-1:0]     r_dx, r_dy;
    logic [2*CW-1:0]   r_sqx, r_sqy;
    logic [RADW-1:0]   r_rad;
    logic [RMW-1:0]    r_rem;
    logic [RB-1:0]     r_root;

    logic [SW-1:0]     sum_sq;
    logic [RMW-1:0]    rem_sh;
    logic [RMW-1:0]    trial;
    logic              ge;
    logic              last_step;

    // One root digit per step
    assign sum_sq    = SW'(r_sqx) + SW'(r_sqy);
    assign rem_sh    = {r_rem[RMW-3:0], r_rad[RADW-1 -: 2]};
    assign trial     = {r_root, 2'b01};
    assign ge        = (rem_sh >= trial);
    assign last_step = (r_cnt == CNTW'(RB - 1));

    // Sequence the phases
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            ctl_pkg::SQ_IDLE:   if (i_start) n_phase = ctl_pkg::SQ_SQUARE;
            ctl_pkg::SQ_SQUARE: n_phase = ctl_pkg::SQ_LOAD;
            ctl_pkg::SQ_LOAD:   n_phase = ctl_pkg::SQ_ITER;
            ctl_pkg::SQ_ITER:   if (last_step) n_phase = ctl_pkg::SQ_IDLE;
            default:            n_phase = ctl_pkg::SQ_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ctl_pkg::SQ_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= (r_phase == ctl_pkg::SQ_ITER) && last_step;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_phase)
            ctl_pkg::SQ_IDLE: begin
                if (i_start) begin
                    r_dx <= (i_ax >= i_bx) ? i_ax - i_bx : i_bx - i_ax;
                    r_dy <= (i_ay >= i_by) ? i_ay - i_by : i_by - i_ay;
                end
            end
            ctl_pkg::SQ_SQUARE: begin
                r_sqx <= r_dx * r_dx;
                r_sqy <= r_dy * r_dy;
            end
            ctl_pkg::SQ_LOAD: begin
                r_rad  <= RADW'(sum_sq) << (2 * FRAC_BITS);
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
            end
            ctl_pkg::SQ_ITER: begin
                r_rad  <= r_rad << 2;
                r_rem  <= ge ? rem_sh - trial : rem_sh;
                r_root <= {r_root[RB-2:0], ge};
                r_cnt  <= r_cnt + CNTW'(1);
            end
            default: ;
        endcase
    end

    assign o_busy = (r_phase != ctl_pkg::SQ_IDLE);
    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

/* design/ctl_dp.sv */
// Tour datapath: point registers, leg unit, saturating sum, output register.
// Depends on ctl_pkg and ctl_sqrt.
`default_nettype none

module ctl_dp #(
    parameter int COORD_BITS = ctl_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = ctl_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire ctl_pkg::t_ctl_cmd           i_cmd,
    output ctl_pkg::t_ctl_stat               o_stat,
    input  wire logic [ctl_pkg::PT_W-1:0]    i_x,
    input  wire logic [ctl_pkg::PT_W-1:0]    i_y,
    input  wire logic                        i_last,
    input  wire logic                        i_out_ready,
    output logic                             o_out_valid,
    output logic [ctl_pkg::SUM_W-1:0]        o_tour_length,
    output logic                             o_saturated
);

    localparam int CW = (COORD_BITS < ctl_pkg::PT_W) ? COORD_BITS : ctl_pkg::PT_W;
    localparam int RB = CW + 1 + FRAC_BITS;
    localparam int SUM_W = ctl_pkg::SUM_W;

    logic [CW-1:0]    r_cur_x, r_cur_y, r_first_x, r_first_y, r_prev_x, r_prev_y;
    logic             r_last;
    logic             r_in_tour;
    logic [SUM_W-1:0] r_sum;
    logic             r_clamp;
    logic             r_out_valid;
    logic [SUM_W-1:0] r_out_len;
    logic             r_out_sat;

    logic [CW-1:0]    op_ax, op_ay, op_bx, op_by;
    logic             sq_start, sq_busy, sq_done;
    logic [RB-1:0]    root;
    logic [SUM_W:0]   sum_wide;
    logic             out_free;

    // Pick the leg endpoints
    assign op_ax    = i_cmd.start_b ? r_cur_x   : r_prev_x;
    assign op_ay    = i_cmd.start_b ? r_cur_y   : r_prev_y;
    assign op_bx    = i_cmd.start_b ? r_first_x : r_cur_x;
    assign op_by    = i_cmd.start_b ? r_first_y : r_cur_y;
    assign sq_start = i_cmd.start_a | i_cmd.start_b;

    ctl_sqrt #(
        .CW        (CW),
        .FRAC_BITS (FRAC_BITS)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_ax    (op_ax),
        .i_ay    (op_ay),
        .i_bx    (op_bx),
        .i_by    (op_by),
        .o_busy  (sq_busy),
        .o_done  (sq_done),
        .o_root  (root)
    );

    assign sum_wide = {1'b0, r_sum} + (SUM_W + 1)'(root);
    assign out_free = !r_out_valid || i_out_ready;

    // Capture the point and track tour endpoints
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pt) begin
            r_cur_x <= i_x[CW-1:0];
            r_cur_y <= i_y[CW-1:0];
            r_last  <= i_last;
        end
        if (i_cmd.first_pt) begin
            r_first_x <= r_cur_x;
            r_first_y <= r_cur_y;
        end
        if (i_cmd.first_pt || i_cmd.add_leg) begin
            r_prev_x <= r_cur_x;
            r_prev_y <= r_cur_y;
        end
        if (i_cmd.emit) begin
            r_out_len <= r_sum;
            r_out_sat <= r_clamp;
        end
    end

    // Accumulate with saturation; clear at tour end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_tour   <= 1'b0;
            r_sum       <= '0;
            r_clamp     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.first_pt) begin
                r_in_tour <= 1'b1;
                r_sum     <= '0;
                r_clamp   <= 1'b0;
            end else if (i_cmd.add_leg) begin
                if (sum_wide[SUM_W]) begin
                    r_sum   <= '1;
                    r_clamp <= 1'b1;
                end else begin
                    r_sum <= sum_wide[SUM_W-1:0];
                end
            end else if (i_cmd.emit) begin
                r_in_tour <= 1'b0;
                r_sum     <= '0;
                r_clamp   <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.in_tour  = r_in_tour;
    assign o_stat.last_pt  = r_last;
    assign o_stat.leg_done = sq_done;
    assign o_stat.sq_busy  = sq_busy;
    assign o_stat.out_free = out_free;

    assign o_out_valid   = r_out_valid;
    assign o_tour_length = r_out_len;
    assign o_saturated   = r_out_sat;

    // A clamped sum sits at full scale
    a_clamp_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clamp |-> (r_sum == '1))
        else $error("clamp flag set with sum below full scale");

    // Emit only lands in a free output register
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> out_free)
        else $error("result written over a waiting result");

    // A leg is only added while a tour is open
    a_add_in_tour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.add_leg |-> r_in_tour)
        else $error("leg added outside a tour");

endmodule

`default_nettype wire

/* design/ctl_ctrl.sv */
// Tour controller: accepts points and sequences leg, closing leg and emit.
// Depends on ctl_pkg for state, command and status types.
`default_nettype none

module ctl_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire ctl_pkg::t_ctl_stat   i_stat,
    output ctl_pkg::t_ctl_cmd         o_cmd
);

    ctl_pkg::t_ctl_state r_state, n_state;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ctl_pkg::S_IDLE: begin
                if (i_in_valid) n_state = ctl_pkg::S_DISPATCH;
            end
            ctl_pkg::S_DISPATCH: begin
                if (i_stat.in_tour) begin
                    n_state = ctl_pkg::S_LEG_A;
                end else if (i_stat.last_pt) begin
                    n_state = ctl_pkg::S_EMIT;
                end else begin
                    n_state = ctl_pkg::S_IDLE;
                end
            end
            ctl_pkg::S_LEG_A: begin
                if (i_stat.leg_done) begin
                    n_state = i_stat.last_pt ? ctl_pkg::S_LEG_B : ctl_pkg::S_IDLE;
                end
            end
            ctl_pkg::S_LEG_B: begin
                if (i_stat.leg_done) n_state = ctl_pkg::S_EMIT;
            end
            ctl_pkg::S_EMIT: begin
                if (i_stat.out_free) n_state = ctl_pkg::S_IDLE;
            end
            default: n_state = ctl_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ctl_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_pt = i_in_valid;
            end
            ctl_pkg::S_DISPATCH: begin
                o_cmd.first_pt = !i_stat.in_tour;
                o_cmd.start_a  = i_stat.in_tour;
            end
            ctl_pkg::S_LEG_A: begin
                o_cmd.add_leg = i_stat.leg_done;
                o_cmd.start_b = i_stat.leg_done && i_stat.last_pt;
            end
            ctl_pkg::S_LEG_B: begin
                o_cmd.add_leg = i_stat.leg_done;
            end
            ctl_pkg::S_EMIT: begin
                o_cmd.emit = i_stat.out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ctl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Never start a leg while the root unit is still running
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.start_a || o_cmd.start_b) |-> !i_stat.sq_busy)
        else $error("leg started on a busy root unit");

    // A finished leg only arrives while a leg is awaited
    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.leg_done |-> (r_state == ctl_pkg::S_LEG_A || r_state == ctl_pkg::S_LEG_B))
        else $error("leg result arrived in an unexpected state");

    // At most one tour-level action per cycle
    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.first_pt, o_cmd.start_a, o_cmd.start_b, o_cmd.emit}))
        else $error("conflicting tour commands");

endmodule

`default_nettype wire

/* design/closed_tour_length.sv */
// Top level of the closed tour length block: controller plus datapath.
// Depends on ctl_pkg, ctl_intf, ctl_sqrt, ctl_dp and ctl_ctrl.
//
//  channel  | dir | payload                        | moves
//  ---------+-----+--------------------------------+--------------------------
//  i_pt     | in  | x[15:0], y[15:0], last         | one tour point per item
//  o_len    | out | tour_length[34:0], saturated   | one closed length per tour
//
// A point other than the first of a tour waits on the root unit, which takes
// |dx| and |dy|, squares them, loads the radicand and then produces one result
// bit per cycle. The last point runs that unit twice, for its leg and the
// closing leg, and then emits; the first point opens the tour without a leg.
// Reset (synchronous, active low) clears the tour and the output valid flag.
// A waiting result does not block new points; only the emit of the next
// tour waits for the output register to be taken.
`default_nettype none

module closed_tour_length #(
    parameter int COORD_BITS = ctl_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = ctl_pkg::FRAC_BITS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    ctl_pt_if.sink        i_pt,
    ctl_len_if.source     o_len
);

    ctl_pkg::t_ctl_cmd  cmd;
    ctl_pkg::t_ctl_stat stat;
    logic               in_ready;

    ctl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pt.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ctl_dp #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_x           (i_pt.x),
        .i_y           (i_pt.y),
        .i_last        (i_pt.last),
        .i_out_ready   (o_len.ready),
        .o_out_valid   (o_len.valid),
        .o_tour_length (o_len.tour_length),
        .o_saturated   (o_len.saturated)
    );

    assign i_pt.ready = in_ready;

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// Self-checking bench for closed_tour_length: drives tour points, predicts each closed
// tour length in SystemVerilog and checks every emitted length in order.
// Depends on ctl_pkg, ctl_intf and the closed_tour_length RTL.
`default_nettype none

module tb_top;

    localparam int PT_W           = ctl_pkg::PT_W;
    localparam int SUM_W          = ctl_pkg::SUM_W;
    localparam int FRAC_BITS      = ctl_pkg::FRAC_BITS_DEF;
    localparam int COORD_BITS     = ctl_pkg::COORD_BITS_DEF;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 100;
    localparam int LONG_TOUR_PTS  = 120;
    localparam int RANDOM_ITEMS   = 660;
    localparam int N_DIRECTED     = 22;
    localparam int MAX_PRINTED    = 60;

    localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [PT_W-1:0]  COORD_MAX = {PT_W{1'b1}};

    typedef struct packed {
        logic [SUM_W-1:0] tour_length;
        logic             saturated;
    } tour_result_t;

    typedef struct packed {
        logic [PT_W-1:0]  x;
        logic [PT_W-1:0]  y;
        logic             last;
        logic             typed;
        logic [SUM_W-1:0] exp_length;
        logic             exp_saturated;
    } point_row_t;

    logic i_clk;
    logic i_rst_n;

    ctl_pt_if  pt_ch ();
    ctl_len_if len_ch ();

    closed_tour_length uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt_ch),
        .o_len   (len_ch)
    );

    // Tour state of the predictor
    logic [PT_W-1:0]  tour_first_x;
    logic [PT_W-1:0]  tour_first_y;
    logic [PT_W-1:0]  tour_prev_x;
    logic [PT_W-1:0]  tour_prev_y;
    logic             tour_open;
    logic [SUM_W-1:0] tour_sum;
    logic             tour_clamped;

    tour_result_t expected_lengths[$];

    int mismatch_count;
    int src_idle_pct;
    int sink_idle_pct;
    int quiet_cycles;

    // Directed points: extremes, one-point tours, saturation-free closed shapes
    point_row_t directed_rows [N_DIRECTED] = '{
        '{16'h0000, 16'h0000, 1'b1, 1'b1, 35'd0,        1'b0},
        '{16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 35'd0,        1'b0},
        '{16'h0000, 16'h0000, 1'b0, 1'b0, 35'd0,        1'b0},
        '{16'h0003, 16'h0004, 1'b1, 1'b1, 35'd2560,     1'b0},
        '{16'hFFFF, 16'h0000, 1'b0, 1'b0, 35'd0,        1'b0},
        '{16'h0000, 16'h0000, 1'b1, 1'b1, 35'd33553920, 1'b0},
        '{16'h0000, 16'h0000, 1'b0, 1'b0, 35'd0,        1'b0},
        '{16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 35'd0,        1'b0},
        '{16'h0000, 16'hFFFF, 1'b0, 1'b0, 35'd0,        1'b0},
        '{16'hFFFF, 16'h0000, 1'b1, 1'b0, 35'd0,        1'b0},
        '{16'h000C, 16'h0005, 1'b0, 1'b0, 35'd0,        1'b0},
        '{16'h0000, 16'h0000, 1'b0, 1'b0, 35'd0,        1'b0},
        '{16'h000C, 16'h0005, 1'b1, 1'b1, 35'd6656,     1'b0},
        '{16'h0001, 16'h0000, 1'b0, 1'b0, 35'd0,        1'b0},
        '{16'h0000, 16'h0001, 1'b1, 1'b0, 35'd0,        1'b0},
        '{16'h5555, 16'hAAAA, 1'b0, 1'b0, 35'd0,        1'b0},
        '{16'hAAAA, 16'h5555, 1'b1, 1'b0, 35'd0,        1'b0},
        '{16'h8000, 16'h7FFF, 1'b0, 1'b0, 35'd0,        1'b0},
        '{16'h7FFF, 16'h8000, 1'b0, 1'b0, 35'd0,        1'b0},
        '{16'h7FFF, 16'h8000, 1'b1, 1'b0, 35'd0,        1'b0},
        '{16'h1234, 16'hFEDC, 1'b0, 1'b0, 35'd0,        1'b0},
        '{16'h1234, 16'hFEDC, 1'b1, 1'b1, 35'd0,        1'b0}
    };

    // Clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Floor of sqrt(r), found one root bit at a time from the top
    function automatic logic [31:0] floor_root(input logic [63:0] r);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= r) begin
                root = trial;
            end
        end
        return root[31:0];
    endfunction

    // Distance between two points in fixed point with FRAC_BITS fraction bits
    function automatic logic [31:0] leg_length(input logic [PT_W-1:0] ax,
                                               input logic [PT_W-1:0] ay,
                                               input logic [PT_W-1:0] bx,
                                               input logic [PT_W-1:0] by);
        logic [63:0] dx;
        logic [63:0] dy;
        dx = (ax > bx) ? 64'(ax - bx) : 64'(bx - ax);
        dy = (ay > by) ? 64'(ay - by) : 64'(by - ay);
        return floor_root((dx * dx + dy * dy) << (2 * FRAC_BITS));
    endfunction

    // Add one leg to the running sum, clamping at the top
    task automatic accumulate_leg(input logic [31:0] d);
        logic [SUM_W:0] t;
        t = {1'b0, tour_sum} + (SUM_W + 1)'(d);
        if (t > {1'b0, SUM_MAX}) begin
            tour_sum     = SUM_MAX;
            tour_clamped = 1'b1;
        end else begin
            tour_sum = t[SUM_W-1:0];
        end
    endtask

    task automatic clear_tour();
        tour_first_x = '0;
        tour_first_y = '0;
        tour_prev_x  = '0;
        tour_prev_y  = '0;
        tour_open    = 1'b0;
        tour_sum     = '0;
        tour_clamped = 1'b0;
    endtask

    // Advance the predicted tour by one accepted point; queue the length on the last one
    task automatic advance_tour(input logic [PT_W-1:0] px, input logic [PT_W-1:0] py,
                                input logic plast, input logic typed,
                                input tour_result_t typed_res);
        logic [PT_W-1:0] mx;
        logic [PT_W-1:0] my;
        tour_result_t    res;
        mx = px & PT_W'((64'd1 << COORD_BITS) - 1);
        my = py & PT_W'((64'd1 << COORD_BITS) - 1);
        if (!tour_open) begin
            tour_first_x = mx;
            tour_first_y = my;
            tour_sum     = '0;
            tour_clamped = 1'b0;
            tour_open    = 1'b1;
        end else begin
            accumulate_leg(leg_length(tour_prev_x, tour_prev_y, mx, my));
        end
        tour_prev_x = mx;
        tour_prev_y = my;
        if (plast) begin
            accumulate_leg(leg_length(mx, my, tour_first_x, tour_first_y));
            res.tour_length = tour_sum;
            res.saturated   = tour_clamped;
            expected_lengths.push_back(typed ? typed_res : res);
            clear_tour();
        end
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED) begin
            $display("MISMATCH @%0t: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    // Offer one point after a random gap; hold it until taken
    task automatic send_point(input logic [PT_W-1:0] px, input logic [PT_W-1:0] py,
                              input logic plast, input logic typed,
                              input tour_result_t typed_res);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            pt_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pt_ch.valid <= 1'b1;
        pt_ch.x     <= px;
        pt_ch.y     <= py;
        pt_ch.last  <= plast;
        @(posedge i_clk);
        while (!pt_ch.ready) begin
            @(posedge i_clk);
        end
        advance_tour(px, py, plast, typed, typed_res);
    endtask

    // Drop valid and hold until every queued length has been taken
    task automatic drain_lengths();
        pt_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_lengths.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic [PT_W-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return COORD_MAX;
            2, 3:    return PT_W'($urandom_range(0, 15));
            4:       return PT_W'(16'h8000 + $urandom_range(0, 15) - 8);
            default: return PT_W'($urandom());
        endcase
    endfunction

    function automatic int pick_tour_len();
        case ($urandom_range(0, 9))
            0:                return 1;
            1, 2, 3, 4, 5, 6: return $urandom_range(2, 4);
            7, 8:             return $urandom_range(5, 12);
            default:          return $urandom_range(13, 40);
        endcase
    endfunction

    // Whole random tours until n_items points have gone out
    task automatic send_random_tours(input int n_items);
        int sent;
        int tlen;
        sent = 0;
        while (sent < n_items) begin
            tlen = pick_tour_len();
            for (int k = 0; k < tlen; k++) begin
                send_point(pick_coord(), pick_coord(), k == tlen - 1, 1'b0, '0);
            end
            sent += tlen;
        end
    endtask

    // Receiver: random stalls on the length channel
    always @(posedge i_clk) begin
        len_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Check each taken length against the oldest expectation
    always @(posedge i_clk) begin : check_lengths
        tour_result_t want;
        if (i_rst_n && len_ch.valid && len_ch.ready) begin
            if (expected_lengths.size() == 0) begin
                report_mismatch($sformatf("unexpected tour length %0d saturated %0b",
                                          len_ch.tour_length, len_ch.saturated));
            end else begin
                want = expected_lengths.pop_front();
                if (len_ch.tour_length !== want.tour_length) begin
                    report_mismatch($sformatf("tour_length got %0d want %0d",
                                              len_ch.tour_length, want.tour_length));
                end
                if (len_ch.saturated !== want.saturated) begin
                    report_mismatch($sformatf("saturated got %0b want %0b",
                                              len_ch.saturated, want.saturated));
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (pt_ch.valid && pt_ch.ready) || (len_ch.valid && len_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_top failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Main sequence
    initial begin
        tour_result_t typed_res;
        i_rst_n        = 1'b0;
        pt_ch.valid    = 1'b0;
        pt_ch.x        = '0;
        pt_ch.y        = '0;
        pt_ch.last     = 1'b0;
        len_ch.ready   = 1'b0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        src_idle_pct   = 25;
        sink_idle_pct  = 57;
        clear_tour();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed points
        foreach (directed_rows[i]) begin
            typed_res.tour_length = directed_rows[i].exp_length;
            typed_res.saturated   = directed_rows[i].exp_saturated;
            send_point(directed_rows[i].x, directed_rows[i].y, directed_rows[i].last,
                       directed_rows[i].typed, typed_res);
        end
        // Hold the sender until every directed length is back
        drain_lengths();

        send_random_tours(RANDOM_ITEMS / 3);
        drain_lengths();

        // Swap the stall pattern; run a long tour of full-diagonal legs
        src_idle_pct  = 57;
        sink_idle_pct = 25;
        for (int k = 0; k < LONG_TOUR_PTS; k++) begin
            send_point(k[0] ? COORD_MAX : '0, k[0] ? COORD_MAX : '0,
                       k == LONG_TOUR_PTS - 1, 1'b0, '0);
        end
        send_random_tours(RANDOM_ITEMS / 3);
        drain_lengths();

        // No stalls on either side
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        send_random_tours(RANDOM_ITEMS / 3);
        drain_lengths();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
